FILE: rtl/reliable_datagram_ack_window_defines.svh
// ----------------------------------------------------------------------------
// reliable datagram ack window assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef RELIABLE_DATAGRAM_ACK_WINDOW_DEFINES_SVH
`define RELIABLE_DATAGRAM_ACK_WINDOW_DEFINES_SVH

// implication checked every clock, reset disabled
`define RDAW_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("rdaw check failed");

// next-cycle implication
`define RDAW_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("rdaw check failed");

`endif

FILE: rtl/rdaw_pkg.sv
// ----------------------------------------------------------------------------
// rdaw_pkg
// shared types and constants of the ack window tracker
// ----------------------------------------------------------------------------
package rdaw_pkg;
  localparam int WINDOW_SLOTS_DEF = 32;
  localparam int HIST_BITS = 32;
  localparam int IN_W = 104;
  localparam int OUT_W = 112;

  localparam logic [1:0] KIND_FREED = 2'd0;
  localparam logic [1:0] KIND_VERDICT = 2'd1;
  localparam logic [1:0] KIND_SENT = 2'd2;
  localparam logic [1:0] KIND_FULL = 2'd3;

  localparam logic CMD_RECV = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  freed_buffer;
    logic [31:0] round_trip;
    logic        is_new;
    logic [15:0] out_sequence;
    logic [15:0] out_ack;
    logic [31:0] out_ack_mask;
    logic        last;
  } result_t;
endpackage

FILE: rtl/rdaw_slot_mem.sv
// ----------------------------------------------------------------------------
// rdaw_slot_mem
// slot store: buffer index and send time, one write and one registered read
// ----------------------------------------------------------------------------
module rdaw_slot_mem #(
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [39:0]       wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [39:0]       rdata
);
  logic [39:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/rdaw_history.sv
// ----------------------------------------------------------------------------
// rdaw_history
// received-sequence history and new/duplicate verdict
// ----------------------------------------------------------------------------
module rdaw_history (
  input  logic        clk,
  input  logic        rst,
  input  logic        upd,
  input  logic [15:0] seq,
  output logic        is_new,
  output logic [15:0] latest,
  output logic [31:0] history
);
  import rdaw_pkg::*;
  logic [15:0] d;
  logic [15:0] back;
  logic        fwd;
  logic [31:0] bit_b;

  always_comb begin
    d = seq - latest;
    back = 16'd0 - d;
    fwd = !d[15] && (d != 16'd0);
    bit_b = 32'd1 << back[4:0];
    bit_b = {bit_b[30:0], 1'b0} >> 1;
    bit_b = 32'd1 << (back[4:0] - 5'd1);
    if (fwd) begin
      is_new = 1'b1;
    end else if (d == 16'd0 || back >= 16'(HIST_BITS)) begin
      is_new = 1'b0;
    end else begin
      is_new = (history & bit_b) == 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latest <= '0;
      history <= '0;
    end else if (upd) begin
      if (fwd) begin
        latest <= seq;
        if (d == 16'(HIST_BITS)) begin
          history <= 32'h8000_0000;
        end else if (d < 16'(HIST_BITS)) begin
          history <= (history << d[4:0]) | (32'd1 << (d[4:0] - 5'd1));
        end else begin
          history <= '0;
        end
      end else if (d != 16'd0 && back < 16'(HIST_BITS)) begin
        history <= history | bit_b;
      end
    end
  end
endmodule

FILE: rtl/reliable_datagram_ack_window.sv
// ----------------------------------------------------------------------------
// reliable_datagram_ack_window
// per-peer send window and receive history for sequenced datagrams
// ----------------------------------------------------------------------------
// One item at a time. A send gives one word. A receive walks the ack and its
// 32 mask bits through the slot memory, one per cycle, but each freed buffer
// holds the walk while its slot is read and its word is loaded into the output
// register, then advances the window start one slot per cycle (at most
// WINDOW_SLOTS slots), then gives its verdict; the item time is set by the
// single read port of the slot memory and the base walk. Results go out
// through an output register; each waits for m_axis_tready, and any stall
// there adds to the item time.
module reliable_datagram_ack_window #(
  parameter int WINDOW_SLOTS = rdaw_pkg::WINDOW_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // seq, ack, ack_mask, tx_buf, now
  input  logic [rdaw_pkg::IN_W-1:0]    s_axis_tdata,
  // cmd
  input  logic                         s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // freed_buffer, round_trip, is_new, out_sequence, out_ack, out_ack_mask
  output logic [rdaw_pkg::OUT_W-1:0]   m_axis_tdata,
  // kind
  output logic [1:0]                   m_axis_tuser,
  output logic                         m_axis_tlast
);
  import rdaw_pkg::*;

  localparam int AW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

  typedef enum logic [2:0] {
    IDLE, ACK_RD, ACK_WAIT, BASE, VERDICT, EMIT
  } state_t;

  function automatic result_t make_word(logic [1:0] kind, logic [7:0] fb,
                                        logic [31:0] rt, logic nw, logic [15:0] os,
                                        logic [15:0] oa, logic [31:0] om, logic lst);
    result_t w;
    w.kind = kind;
    w.freed_buffer = fb;
    w.round_trip = rt;
    w.is_new = nw;
    w.out_sequence = os;
    w.out_ack = oa;
    w.out_ack_mask = om;
    w.last = lst;
    return w;
  endfunction

  state_t state;
  logic [15:0] seq, ack;
  logic [31:0] mask, now;
  logic [WINDOW_SLOTS-1:0] pending;
  logic [15:0] base, nls;
  logic [5:0] cnt;
  logic       p_v;
  logic [AW-1:0] p_slot;
  logic [AW-1:0] rd_slot;
  logic [39:0] rdata;
  logic       we;
  logic [AW-1:0] waddr;
  logic       h_new, h_upd;
  logic       load;
  logic [15:0] latest;
  logic [31:0] history;
  result_t    res;
  logic [AW:0] guard;

  logic [15:0] cur_s, cur_d;
  logic [AW-1:0] cur_slot, nls_slot, base_slot;
  logic cur_ok, full;

  always_comb begin
    cur_s = (cnt == 6'd0) ? ack : ack - 16'(cnt);
    cur_d = cur_s - base;
    cur_slot = AW'(cur_s % 16'(WINDOW_SLOTS));
    nls_slot = AW'(nls % 16'(WINDOW_SLOTS));
    base_slot = AW'(base % 16'(WINDOW_SLOTS));
    cur_ok = ((cnt == 6'd0) || mask[cnt[4:0] - 5'd1]) &&
             (cur_d < 16'(WINDOW_SLOTS)) && pending[cur_slot];
    full = pending[nls_slot] ||
           ((pending != '0) && ((nls - base) >= 16'(WINDOW_SLOTS)));
    // hold the read address on the hit slot until its word is loaded
    rd_slot = p_v ? p_slot : cur_slot;
    we = (state == IDLE) && s_axis_tvalid && s_axis_tready &&
         (s_axis_tuser == CMD_SEND) && !full;
    waddr = nls_slot;
    h_upd = (state == VERDICT) && !m_axis_tvalid;
    load = ((state == IDLE) && s_axis_tvalid && s_axis_tready &&
            (s_axis_tuser == CMD_SEND)) ||
           ((state == ACK_RD) && p_v && (!m_axis_tvalid || m_axis_tready)) ||
           h_upd;
  end

  rdaw_slot_mem #(.ADDR_W(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr),
    .wdata({s_axis_tdata[71:64], s_axis_tdata[103:72]}),
    .raddr(rd_slot), .rdata(rdata)
  );

  rdaw_history u_hist (
    .clk(clk), .rst(rst), .upd(h_upd), .seq(seq),
    .is_new(h_new), .latest(latest), .history(history)
  );

  assign s_axis_tready = (state == IDLE) && !m_axis_tvalid;
  assign m_axis_tdata = {7'd0, res.out_ack_mask, res.out_ack, res.out_sequence, res.is_new,
                         res.round_trip, res.freed_buffer};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      pending <= '0;
      base <= '0;
      nls <= '0;
      m_axis_tvalid <= 1'b0;
      cnt <= '0;
      p_v <= 1'b0;
      guard <= '0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            seq <= s_axis_tdata[15:0];
            ack <= s_axis_tdata[31:16];
            mask <= s_axis_tdata[63:32];
            now <= s_axis_tdata[103:72];
            if (s_axis_tuser == CMD_SEND) begin
              if (full) begin
                res <= make_word(KIND_FULL, 8'd0, 32'd0, 1'b0, 16'd0, 16'd0, 32'd0, 1'b1);
              end else begin
                res <= make_word(KIND_SENT, 8'd0, 32'd0, 1'b0, nls, latest, history, 1'b1);
                if (pending == '0) begin
                  base <= nls;
                end
                pending[nls_slot] <= 1'b1;
                nls <= nls + 16'd1;
              end
            end else begin
              cnt <= '0;
              p_v <= 1'b0;
              state <= ACK_RD;
            end
          end
        end
        ACK_RD: begin
          // p_v: a hit read last cycle, rdata now valid
          if (p_v) begin
            if (!m_axis_tvalid || m_axis_tready) begin
              res <= make_word(KIND_FREED, rdata[39:32], now - rdata[31:0], 1'b0,
                               16'd0, 16'd0, 32'd0, 1'b0);
              p_v <= 1'b0;
            end
          end else if (cnt == 6'd33) begin
            guard <= '0;
            state <= BASE;
          end else begin
            if (cur_ok) begin
              pending[cur_slot] <= 1'b0;
              p_v <= 1'b1;
              p_slot <= cur_slot;
            end
            cnt <= cnt + 6'd1;
          end
        end
        BASE: begin
          if (pending == '0) begin
            base <= nls;
            state <= VERDICT;
          end else if (pending[base_slot] || guard == (AW+1)'(WINDOW_SLOTS)) begin
            state <= VERDICT;
          end else begin
            base <= base + 16'd1;
            guard <= guard + 1'b1;
          end
        end
        VERDICT: begin
          if (!m_axis_tvalid) begin
            res <= make_word(KIND_VERDICT, 8'd0, 32'd0, h_new, 16'd0, 16'd0, 32'd0, 1'b1);
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/rdaw_checker.sv
// ----------------------------------------------------------------------------
// rdaw_checker
// port-level checks of the ack window tracker
// ----------------------------------------------------------------------------
`include "reliable_datagram_ack_window_defines.svh"
module rdaw_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tuser,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);
  import rdaw_pkg::*;
  `RDAW_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `RDAW_ASSERT_IMPL(a_freed_not_last, clk, rst,
    m_axis_tvalid && m_axis_tuser == KIND_FREED, !m_axis_tlast)
  `RDAW_ASSERT_IMPL(a_other_last, clk, rst,
    m_axis_tvalid && m_axis_tuser != KIND_FREED, m_axis_tlast)
  `RDAW_ASSERT_NEXT(a_send_answer, clk, rst,
    s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_SEND,
    m_axis_tvalid && (m_axis_tuser == KIND_SENT || m_axis_tuser == KIND_FULL))
endmodule

bind reliable_datagram_ack_window rdaw_checker u_rdaw_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tuser(m_axis_tuser),
  .m_axis_tlast(m_axis_tlast)
);

FILE: test/tb_reliable_datagram_ack_window.sv
// ----------------------------------------------------------------------------
// tb_reliable_datagram_ack_window
// drives send and receive headers into the ack window tracker, predicts the
// freed buffers, round trips, verdicts and header fields, and checks each word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reliable_datagram_ack_window;
  import rdaw_pkg::*;

  localparam int SLOTS = 32;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic        cmd;
    logic [15:0] seq;
    logic [15:0] ack;
    logic [31:0] ack_mask;
    logic [7:0]  tx_buf;
    logic [31:0] now;
  } pkt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  reliable_datagram_ack_window u_top (.*);

  always #5 clk = ~clk;

  pkt_t    pkt_queue[$];
  result_t expected_words[$];
  int      errors = 0;
  int      n_freed = 0, n_verdict = 0, n_sent = 0, n_full = 0;
  longint  cycles = 0;
  int      hold_off = 0;
  bit      hold_req = 0;
  bit      hold_seen = 0;
  bit      stimulus_done = 0;

  // tracker copy
  logic [31:0] pend;
  logic [15:0] base, next_seq, remote_seq;
  logic [31:0] history;
  logic [7:0]  slot_buf[SLOTS];
  logic [31:0] slot_time[SLOTS];
  logic [31:0] clock_ticks = 0;
  logic [15:0] next_guess = 0, remote_guess = 0;

  function automatic result_t blank(logic [1:0] k);
    result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic void release_ack(logic [15:0] s, logic [31:0] t);
    logic [15:0] d;
    result_t r;
    d = s - base;
    if (d >= SLOTS) return;
    if (!pend[s[4:0]]) return;
    r = blank(KIND_FREED);
    r.freed_buffer = slot_buf[s[4:0]];
    r.round_trip = t - slot_time[s[4:0]];
    expected_words.push_back(r);
    pend[s[4:0]] = 1'b0;
  endfunction

  function automatic void predict_words(pkt_t p);
    result_t r;
    logic [15:0] ud;
    int d;
    logic [31:0] bit_m;
    if (p.cmd == CMD_SEND) begin
      if (pend[next_seq[4:0]] || (pend != 0 && 16'(next_seq - base) >= SLOTS)) begin
        r = blank(KIND_FULL);
      end else begin
        if (pend == 0) base = next_seq;
        slot_buf[next_seq[4:0]] = p.tx_buf;
        slot_time[next_seq[4:0]] = p.now;
        pend[next_seq[4:0]] = 1'b1;
        r = blank(KIND_SENT);
        r.out_sequence = next_seq;
        r.out_ack = remote_seq;
        r.out_ack_mask = history;
        next_seq = next_seq + 16'd1;
      end
      r.last = 1'b1;
      expected_words.push_back(r);
      return;
    end
    release_ack(p.ack, p.now);
    for (int i = 0; i < 32; i++)
      if (p.ack_mask[i]) release_ack(p.ack - 16'(i) - 16'd1, p.now);
    while (pend != 0 && !pend[base[4:0]]) base = base + 16'd1;
    if (pend == 0) base = next_seq;
    r = blank(KIND_VERDICT);
    ud = p.seq - remote_seq;
    d = int'($signed(ud));
    if (d > 0) begin
      if (d <= 32) begin
        history = (d == 32) ? 32'd0 : (history << d);
        history[d-1] = 1'b1;
      end else begin
        history = '0;
      end
      remote_seq = p.seq;
      r.is_new = 1'b1;
    end else if (d == 0 || -d >= 32) begin
      r.is_new = 1'b0;
    end else begin
      bit_m = 32'd1 << (-d - 1);
      r.is_new = (history & bit_m) == 0;
      history = history | bit_m;
    end
    r.last = 1'b1;
    expected_words.push_back(r);
  endfunction

  function automatic pkt_t send_pkt(logic [7:0] b);
    pkt_t p;
    p = '0;
    p.cmd = CMD_SEND;
    p.tx_buf = b;
    p.now = clock_ticks;
    p.seq = 16'($urandom);
    p.ack = 16'($urandom);
    p.ack_mask = $urandom;
    return p;
  endfunction

  function automatic pkt_t recv_pkt(logic [15:0] s, logic [15:0] a, logic [31:0] m);
    pkt_t p;
    p = '0;
    p.cmd = CMD_RECV;
    p.seq = s;
    p.ack = a;
    p.ack_mask = m;
    p.tx_buf = 8'($urandom);
    p.now = clock_ticks;
    return p;
  endfunction

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_words(pkt_queue.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pkt_queue.size() > 0) begin
          s_axis_tdata <= {pkt_queue[0].now, pkt_queue[0].tx_buf,
                           pkt_queue[0].ack_mask, pkt_queue[0].ack, pkt_queue[0].seq};
          s_axis_tuser <= pkt_queue[0].cmd;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 80);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_seen) begin
      hold_seen <= 1'b1;
      hold_off <= 3000;
      m_axis_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 400;
      if (stall_phase < 150) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got, want;
    cycles++;
    clock_ticks <= clock_ticks + $urandom_range(1, 20);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '0;
      got.kind = m_axis_tuser;
      {got.out_ack_mask, got.out_ack, got.out_sequence, got.is_new,
       got.round_trip, got.freed_buffer} = m_axis_tdata[104:0];
      got.last = m_axis_tlast;
      case (got.kind)
        KIND_FREED: n_freed++;
        KIND_VERDICT: n_verdict++;
        KIND_SENT: n_sent++;
        default: n_full++;
      endcase
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch kind exp %0d act %0d buf exp %0d act %0d",
                   $time, want.kind, got.kind, want.freed_buffer, got.freed_buffer);
          $display("  rtt exp %0d act %0d new exp %0d act %0d seq exp %0d act %0d",
                   want.round_trip, got.round_trip, want.is_new, got.is_new,
                   want.out_sequence, got.out_sequence);
          $display("  ack exp %h act %h mask exp %h act %h last exp %0d act %0d",
                   want.out_ack, got.out_ack, want.out_ack_mask, got.out_ack_mask,
                   want.last, got.last);
          errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic load_random(int count);
    int k;
    logic [15:0] s;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        pkt_queue.push_back(send_pkt(8'($urandom)));
      end else if (k < 85) begin
        // plausible ack of recent sends
        s = next_guess - 16'($urandom_range(1, 6));
        pkt_queue.push_back(recv_pkt(remote_guess + 16'($urandom_range(0, 40)) - 16'd6,
                                     s, $urandom & $urandom));
        remote_guess = remote_guess + 16'($urandom_range(0, 3));
      end else begin
        pkt_queue.push_back(recv_pkt(16'($urandom), 16'($urandom), $urandom));
      end
      if (k < 45) next_guess = next_guess + 16'd1;
    end
  endtask

  initial begin
    pend = '0; base = '0; next_seq = '0; remote_seq = '0; history = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes and special cases
    pkt_queue.push_back(recv_pkt(16'd0, 16'd0, 32'd0));            // duplicate at reset
    pkt_queue.push_back(recv_pkt(16'd32, 16'd5, 32'hFFFFFFFF));    // shift by 32
    pkt_queue.push_back(recv_pkt(16'd100, 16'hFFFF, 32'd0));       // far newer
    pkt_queue.push_back(recv_pkt(16'd99, 16'd0, 32'd0));           // older within history
    pkt_queue.push_back(recv_pkt(16'd99, 16'd0, 32'd0));           // repeated older
    pkt_queue.push_back(recv_pkt(16'd68, 16'd0, 32'd0));           // too old
    pkt_queue.push_back(recv_pkt(16'hFFFF, 16'd0, 32'd0));         // wrapped old
    for (int i = 0; i < 33; i++) begin
      pkt_queue.push_back(send_pkt(i == 0 ? 8'hFF : 8'(i)));       // fill, then reject
      pkt_queue[$].now = (i == 0) ? 32'hFFFFFFFF : 32'(i * 3);
    end
    pkt_queue.push_back(recv_pkt(16'h8000, 16'd31, 32'h7FFFFFFF)); // free all, repeats
    pkt_queue.push_back(recv_pkt(16'd0, 16'd40, 32'hFFFFFFFF));    // outside window
    next_guess = 16'd32;
    remote_guess = 16'h8000;
    load_random(210);
    wait (pkt_queue.size() == 0);
    // long receiver hold-off while the sender keeps pushing
    hold_req = 1'b1;
    load_random(210);
    wait (pkt_queue.size() == 0);
    wait (expected_words.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d freed, %0d verdicts, %0d sends accepted, %0d rejected",
             n_freed, n_verdict, n_sent, n_full);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
